// ----- hdl/tlbpt_pkg.sv -----
// Shared constants for the TLB and page table address translator.
`default_nettype none

package tlbpt_pkg;

	localparam int TLB_ENTRIES_DEF = 16;
	localparam int PAGE_COUNT_DEF = 256;
	localparam int FRAME_COUNT_DEF = 256;
	localparam int OFFSET_BITS_DEF = 8;

	localparam int ADDR_W = 16;
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

`default_nettype wire

// ----- hdl/tlbpt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tlbpt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/tlbpt_cmod.sv -----
// Two-stage remainder by a constant divisor using a reciprocal multiply.
`default_nettype none

module tlbpt_cmod #(
	parameter int IN_W = 8,
	parameter int DIV = 256,
	parameter int R_W = 8
) (
	input  wire logic            clk,
	input  wire logic [IN_W-1:0] x,
	output logic      [R_W-1:0]  r
);

	localparam int SH = IN_W + R_W;
	localparam int M_W = IN_W + 2;
	localparam longint MULT = ((longint'(1) << SH) + longint'(DIV) - 1) / longint'(DIV);
	localparam int PROD_W = IN_W + M_W;
	localparam int CALC_W = IN_W + R_W + 2;

	logic [M_W-1:0]    mult_c;
	logic [IN_W-1:0]   x_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [CALC_W-1:0] quot;
	logic [R_W-1:0]    r_s2;

	assign mult_c = M_W'(MULT);

	// The reciprocal is rounded up with enough extra bits that the quotient is exact.
	always_ff @(posedge clk) begin
		x_s1 <= x;
		prod_s1 <= {{M_W{1'b0}}, x} * {{IN_W{1'b0}}, mult_c};
	end

	assign quot = CALC_W'(prod_s1 >> SH);

	always_ff @(posedge clk) begin
		r_s2 <= R_W'(CALC_W'(x_s1) - quot * CALC_W'(DIV));
	end

	assign r = r_s2;

endmodule

`default_nettype wire

// ----- hdl/tlbpt_cell.sv -----
// One TLB entry cell: holds a mapping, shifts it on, and checks a passing probe.
`default_nettype none

module tlbpt_cell #(
	parameter int PAGE_W = 8,
	parameter int FRAME_W = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               shift_en,
	input  wire logic               prev_vld,
	input  wire logic [PAGE_W-1:0]  prev_page,
	input  wire logic [FRAME_W-1:0] prev_frame,
	output logic                    ent_vld,
	output logic      [PAGE_W-1:0]  ent_page,
	output logic      [FRAME_W-1:0] ent_frame,
	input  wire logic               pi_vld,
	input  wire logic [PAGE_W-1:0]  pi_page,
	input  wire logic               pi_found,
	input  wire logic [FRAME_W-1:0] pi_frame,
	output logic                    po_vld,
	output logic      [PAGE_W-1:0]  po_page,
	output logic                    po_found,
	output logic      [FRAME_W-1:0] po_frame
);

	logic               ent_vld_q;
	logic [PAGE_W-1:0]  ent_page_q;
	logic [FRAME_W-1:0] ent_frame_q;
	logic               po_vld_q;
	logic [PAGE_W-1:0]  po_page_q;
	logic               po_found_q;
	logic [FRAME_W-1:0] po_frame_q;
	logic               match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			po_vld_q <= 1'b0;
		end else begin
			if (shift_en) begin
				ent_vld_q <= prev_vld;
			end
			po_vld_q <= pi_vld;
		end
	end

	// Only the first matching cell along the chain supplies the frame.
	assign match = ent_vld_q && (ent_page_q == pi_page) && !pi_found;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			ent_page_q <= prev_page;
			ent_frame_q <= prev_frame;
		end
		po_page_q <= pi_page;
		po_found_q <= pi_found || match;
		po_frame_q <= match ? ent_frame_q : pi_frame;
	end

	assign ent_vld = ent_vld_q;
	assign ent_page = ent_page_q;
	assign ent_frame = ent_frame_q;
	assign po_vld = po_vld_q;
	assign po_page = po_page_q;
	assign po_found = po_found_q;
	assign po_frame = po_frame_q;

endmodule

`default_nettype wire

// ----- hdl/tlb_page_table_translator.sv -----
// Top level of the TLB and page table address translator.
// An accepted input beat passes through the page and frame remainder units, then the TLB probe, then commits.
// Only one beat is in flight: in_ready stays low until it commits; the probe walks the cell chain one cell a cycle.
// After reset the page table valid RAM is cleared, one entry a cycle, over all PAGE_COUNT entries.
// in_ready stays low during that pass; the TLB and both totals clear at once.
`default_nettype none

module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
	parameter int PAGE_COUNT = tlbpt_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT = tlbpt_pkg::FRAME_COUNT_DEF,
	parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [tlbpt_pkg::ADDR_W-1:0] logical_address,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [tlbpt_pkg::ADDR_W-1:0] physical_address,
	output logic                              tlb_hit,
	output logic                              table_miss,
	output logic      [tlbpt_pkg::CNT_W-1:0]  hit_total,
	output logic      [tlbpt_pkg::CNT_W-1:0]  miss_total
);

	localparam int ADDR_W = tlbpt_pkg::ADDR_W;
	localparam int CNT_W = tlbpt_pkg::CNT_W;
	localparam int RAW_W = (ADDR_W > OFFSET_BITS) ? ADDR_W - OFFSET_BITS : 1;
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int FRAME_W = $clog2(FRAME_COUNT);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MOD = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;
	localparam logic [1:0] MOD_WAIT = 2'd3;

	logic [2:0]         state_q;
	logic [1:0]         wait_q;
	logic [PAGE_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [RAW_W-1:0]   raw_page;
	logic [PAGE_W-1:0]  page_r;
	logic [FRAME_W-1:0] frame_r;
	logic               found_q;
	logic [FRAME_W-1:0] hit_frame_q;
	logic               pt_valid;
	logic               commit;
	logic               fill;
	logic               launch;
	logic [FRAME_W-1:0] frame_sel;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  phys_q;
	logic               hit_flag_q;
	logic               tmiss_q;
	logic [CNT_W-1:0]   hit_q;
	logic [CNT_W-1:0]   miss_q;
	logic               pt_we;
	logic [PAGE_W-1:0]  pt_waddr;

	logic               ent_vld   [TLB_ENTRIES];
	logic [PAGE_W-1:0]  ent_page  [TLB_ENTRIES];
	logic [FRAME_W-1:0] ent_frame [TLB_ENTRIES];
	logic               pr_vld    [TLB_ENTRIES+1];
	logic [PAGE_W-1:0]  pr_page   [TLB_ENTRIES+1];
	logic               pr_found  [TLB_ENTRIES+1];
	logic [FRAME_W-1:0] pr_frame  [TLB_ENTRIES+1];

	assign raw_page = RAW_W'(addr_q >> OFFSET_BITS);

	tlbpt_cmod #(
		.IN_W(RAW_W),
		.DIV(PAGE_COUNT),
		.R_W(PAGE_W)
	) u_page_mod (
		.clk(clk),
		.x(raw_page),
		.r(page_r)
	);

	tlbpt_cmod #(
		.IN_W(PAGE_W),
		.DIV(FRAME_COUNT),
		.R_W(FRAME_W)
	) u_frame_mod (
		.clk(clk),
		.x(page_r),
		.r(frame_r)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign launch = (state_q == ST_MOD) && (wait_q == MOD_WAIT);
	assign commit = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign fill = !found_q && !pt_valid;
	assign frame_sel = found_q ? hit_frame_q : frame_r;

	assign pr_vld[0] = launch;
	assign pr_page[0] = page_r;
	assign pr_found[0] = 1'b0;
	assign pr_frame[0] = '0;

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		logic               prev_vld;
		logic [PAGE_W-1:0]  prev_page;
		logic [FRAME_W-1:0] prev_frame;

		if (i == 0) begin : g_head
			assign prev_vld = 1'b1;
			assign prev_page = page_r;
			assign prev_frame = frame_r;
		end else begin : g_body
			assign prev_vld = ent_vld[i-1];
			assign prev_page = ent_page[i-1];
			assign prev_frame = ent_frame[i-1];
		end

		tlbpt_cell #(
			.PAGE_W(PAGE_W),
			.FRAME_W(FRAME_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.shift_en(commit && !found_q),
			.prev_vld(prev_vld),
			.prev_page(prev_page),
			.prev_frame(prev_frame),
			.ent_vld(ent_vld[i]),
			.ent_page(ent_page[i]),
			.ent_frame(ent_frame[i]),
			.pi_vld(pr_vld[i]),
			.pi_page(pr_page[i]),
			.pi_found(pr_found[i]),
			.pi_frame(pr_frame[i]),
			.po_vld(pr_vld[i+1]),
			.po_page(pr_page[i+1]),
			.po_found(pr_found[i+1]),
			.po_frame(pr_frame[i+1])
		);
	end

	assign pt_we = (state_q == ST_CLEAR) || (commit && fill);
	assign pt_waddr = (state_q == ST_CLEAR) ? clr_q : page_r;

	tlbpt_ram #(
		.WIDTH(1),
		.DEPTH(PAGE_COUNT)
	) u_pt_valid (
		.clk(clk),
		.we(pt_we),
		.waddr(pt_waddr),
		.wdata(state_q != ST_CLEAR),
		.raddr(page_r),
		.rdata(pt_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wait_q <= '0;
			clr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PAGE_W'(PAGE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						wait_q <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == MOD_WAIT) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (pr_vld[TLB_ENTRIES]) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_q <= logical_address;
		end
		if ((state_q == ST_SEARCH) && pr_vld[TLB_ENTRIES]) begin
			found_q <= pr_found[TLB_ENTRIES];
			hit_frame_q <= pr_frame[TLB_ENTRIES];
		end
		if (commit) begin
			phys_q <= ADDR_W'({frame_sel, addr_q[OFFSET_BITS-1:0]});
			hit_flag_q <= found_q;
			tmiss_q <= fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_q <= '0;
			miss_q <= '0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				if (found_q) begin
					if (hit_q != tlbpt_pkg::CNT_MAX) begin
						hit_q <= hit_q + 1'b1;
					end
				end else if (miss_q != tlbpt_pkg::CNT_MAX) begin
					miss_q <= miss_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign physical_address = phys_q;
	assign tlb_hit = hit_flag_q;
	assign table_miss = tmiss_q;
	assign hit_total = hit_q;
	assign miss_total = miss_q;

endmodule

`default_nettype wire

// ----- hdl/tlbpt_checker.sv -----
// Port-level checks for the translator, bound to the top level.
`default_nettype none

module tlbpt_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [tlbpt_pkg::ADDR_W-1:0] physical_address,
	input wire logic                         tlb_hit,
	input wire logic                         table_miss,
	input wire logic [tlbpt_pkg::CNT_W-1:0]  hit_total,
	input wire logic [tlbpt_pkg::CNT_W-1:0]  miss_total
);

	// A stalled output beat keeps its address and totals.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(physical_address)
			&& $stable(hit_total) && $stable(miss_total))
		else $error("output beat changed while stalled");

	// A page table fill only happens on a TLB miss.
	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && table_miss))
		else $error("TLB hit reported together with a table miss");

	// The total matching the reported outcome has counted this beat.
	a_total_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tlb_hit ? (hit_total != '0) : (miss_total != '0)))
		else $error("total does not include the reported beat");

	// Totals never decrease.
	a_totals_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hit_total >= $past(hit_total)) && (miss_total >= $past(miss_total)))
		else $error("hit or miss total decreased");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire
